// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/twa_pkg.sv
package twa_pkg;

    localparam int DivSteps = 32;

    localparam logic [3:0] KIND_ADD    = 4'd0;
    localparam logic [3:0] KIND_SUB    = 4'd1;
    localparam logic [3:0] KIND_MUL    = 4'd2;
    localparam logic [3:0] KIND_DIV    = 4'd3;
    localparam logic [3:0] KIND_NUMEQ  = 4'd4;
    localparam logic [3:0] KIND_LESS   = 4'd5;
    localparam logic [3:0] KIND_LESSEQ = 4'd6;
    localparam logic [3:0] KIND_EQ     = 4'd7;
    localparam logic [3:0] KIND_ISINT  = 4'd8;
    localparam logic [3:0] KIND_ISVOID = 4'd9;
    localparam logic [3:0] KIND_ISPROC = 4'd10;
    localparam logic [3:0] KIND_ISNULL = 4'd11;
    localparam logic [3:0] KIND_ISCONS = 4'd12;
    localparam logic [3:0] KIND_NOT    = 4'd13;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_A_TAG = 2'd1;
    localparam logic [1:0] ERR_B_TAG = 2'd2;
    localparam logic [1:0] ERR_DIV0  = 2'd3;

    localparam logic [2:0] TAG_INT  = 3'd2;
    localparam logic [2:0] TAG_PROC = 3'd0;
    localparam logic [2:0] TAG_CONS = 3'd1;

    localparam logic [63:0] WORD_TRUE  = 64'd31;
    localparam logic [63:0] WORD_FALSE = 64'd15;
    localparam logic [63:0] WORD_VOID  = 64'd39;
    localparam logic [63:0] WORD_NULL  = 64'd0;

    // One item as it travels down the divider chain.
    typedef struct packed {
        logic        is_div;
        logic        neg_q;
        logic [1:0]  err;
        logic [63:0] res;
        logic [31:0] rem;
        logic [31:0] dvs;
        logic [31:0] quo;
    } t_lane;

    function automatic logic [63:0] pack_int_word(input logic [31:0] value);
        return {value, 29'd0, TAG_INT};
    endfunction

endpackage

// File: hw/rtl/twa_front.sv
module twa_front import twa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    output t_lane       o_lane,
    input  logic        i_ready
);

    logic        r_valid;
    t_lane       r_lane;
    t_lane       n_lane;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [31:0] w_prod;
    logic        w_a_int;
    logic        w_b_int;
    logic        w_lt;
    logic        w_eq;

    assign w_x     = i_operand_a[63:32];
    assign w_y     = i_operand_b[63:32];
    assign w_a_int = (i_operand_a[2:0] == TAG_INT);
    assign w_b_int = (i_operand_b[2:0] == TAG_INT);
    assign w_lt    = ($signed(w_x) < $signed(w_y));
    assign w_eq    = (w_x == w_y);
    assign w_prod  = w_x * w_y;

    always_comb begin
        n_lane        = '0;
        n_lane.res    = WORD_FALSE;
        n_lane.err    = ERR_NONE;
        n_lane.neg_q  = w_x[31] ^ w_y[31];
        n_lane.quo    = w_x[31] ? (~w_x + 32'd1) : w_x;
        n_lane.dvs    = w_y[31] ? (~w_y + 32'd1) : w_y;
        n_lane.rem    = '0;
        n_lane.is_div = 1'b0;
        if (i_kind <= KIND_LESSEQ) begin
            if (!w_a_int) begin
                n_lane.err = ERR_A_TAG;
            end else if (!w_b_int) begin
                n_lane.err = ERR_B_TAG;
            end else begin
                unique case (i_kind)
                    KIND_ADD:   n_lane.res = pack_int_word(w_x + w_y);
                    KIND_SUB:   n_lane.res = pack_int_word(w_x - w_y);
                    KIND_MUL:   n_lane.res = pack_int_word(w_prod);
                    KIND_DIV: begin
                        if (w_y == 32'd0) begin
                            n_lane.err = ERR_DIV0;
                        end else begin
                            n_lane.is_div = 1'b1;
                        end
                    end
                    KIND_NUMEQ: n_lane.res = w_eq ? WORD_TRUE : WORD_FALSE;
                    KIND_LESS:  n_lane.res = w_lt ? WORD_TRUE : WORD_FALSE;
                    default:    n_lane.res = (w_lt || w_eq) ? WORD_TRUE : WORD_FALSE;
                endcase
            end
        end else begin
            unique case (i_kind)
                KIND_EQ:
                    n_lane.res = (i_operand_a == i_operand_b) ? WORD_TRUE : WORD_FALSE;
                KIND_ISINT:
                    n_lane.res = w_a_int ? WORD_TRUE : WORD_FALSE;
                KIND_ISVOID:
                    n_lane.res = (i_operand_a == WORD_VOID) ? WORD_TRUE : WORD_FALSE;
                KIND_ISPROC:
                    n_lane.res = (i_operand_a[2:0] == TAG_PROC) ? WORD_TRUE : WORD_FALSE;
                KIND_ISNULL:
                    n_lane.res = (i_operand_a == WORD_NULL) ? WORD_TRUE : WORD_FALSE;
                KIND_ISCONS:
                    n_lane.res = (i_operand_a[2:0] == TAG_CONS) ? WORD_TRUE : WORD_FALSE;
                KIND_NOT:
                    n_lane.res = (i_operand_a == WORD_FALSE) ? WORD_TRUE : WORD_FALSE;
                default:
                    n_lane.res = WORD_FALSE;
            endcase
        end
        // errors always report a zero word
        if (n_lane.err != ERR_NONE) begin
            n_lane.res = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: hw/rtl/twa_div_cell.sv
module twa_div_cell import twa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane,
    input  logic  i_ready
);

    logic        r_valid;
    t_lane       r_lane;
    t_lane       n_lane;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign w_trial = {i_lane.rem, i_lane.quo[31]};
    assign w_diff  = w_trial - {1'b0, i_lane.dvs};
    assign w_ge    = (w_trial >= {1'b0, i_lane.dvs});

    always_comb begin
        n_lane     = i_lane;
        n_lane.rem = w_ge ? w_diff[31:0] : w_trial[31:0];
        n_lane.quo = {i_lane.quo[30:0], w_ge};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: hw/rtl/twa_back.sv
module twa_back import twa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_lane       i_lane,
    output logic        o_valid,
    output logic [63:0] o_result_word,
    output logic [1:0]  o_error_code,
    input  logic        i_ready
);

    logic        r_valid;
    logic [63:0] r_result_word;
    logic [1:0]  r_error_code;
    logic [31:0] w_quot;
    logic [63:0] n_result_word;

    // Apply the quotient sign; minimum over minus one wraps back to minimum.
    assign w_quot        = i_lane.neg_q ? (~i_lane.quo + 32'd1) : i_lane.quo;
    assign n_result_word = i_lane.is_div ? pack_int_word(w_quot) : i_lane.res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_result_word <= n_result_word;
            r_error_code  <= i_lane.err;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_word = r_result_word;
    assign o_error_code  = r_error_code;

endmodule

// File: hw/rtl/tagged_word_alu_top.sv
// Path from input transfer to result: decode register, 32 divider cells,
// output register, the same for every operation. Throughput: one item
// per cycle unless the output stalls; each cell retires one quotient bit.
// Each stage holds its item until the next one frees, so bubbles close up under stall.
// Reset (synchronous, active low) empties all stages; no other state exists.
module tagged_word_alu_top import twa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_word,
    output logic [1:0]  o_error_code
);

    logic  w_valid [0:DivSteps];
    logic  w_ready [0:DivSteps];
    t_lane w_lane  [0:DivSteps];

    twa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (w_valid[0]),
        .o_lane      (w_lane[0]),
        .i_ready     (w_ready[0])
    );

    for (genvar g = 0; g < DivSteps; g++) begin : g_cell
        twa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    twa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid[DivSteps]),
        .o_ready       (w_ready[DivSteps]),
        .i_lane        (w_lane[DivSteps]),
        .o_valid       (o_valid),
        .o_result_word (o_result_word),
        .o_error_code  (o_error_code),
        .i_ready       (i_ready)
    );

endmodule

// File: hw/rtl/twa_checker.sv
`include "assert_macros.svh"

module twa_checker import twa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [3:0]  i_kind,
    input logic [63:0] i_operand_a,
    input logic [63:0] i_operand_b,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_word,
    input logic [1:0]  o_error_code
);

    logic        w_err_out;
    logic        w_ok_out;
    logic        w_word_form;
    logic        w_stall;
    logic [65:0] w_out_bits;

    assign w_err_out   = o_valid && (o_error_code != ERR_NONE);
    assign w_ok_out    = o_valid && (o_error_code == ERR_NONE);
    assign w_word_form = (o_result_word[2:0] == TAG_INT) || (o_result_word == WORD_TRUE)
                         || (o_result_word == WORD_FALSE);
    assign w_stall     = o_valid && !i_ready;
    assign w_out_bits  = {o_result_word, o_error_code};

    // nothing can come out in the cycle right after reset
    `ASSERT_SAME(a_empty_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !o_valid)

    `ASSERT_SAME(a_error_zero_word, i_clk, i_rst_n, w_err_out, o_result_word == 64'd0)

    `ASSERT_SAME(a_ok_word_form, i_clk, i_rst_n, w_ok_out, w_word_form)

    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_stall, o_valid && $stable(w_out_bits))

    `ASSERT_ALWAYS(a_ready_when_out_free, i_clk, i_rst_n, !(!o_ready && !o_valid))

endmodule

bind tagged_word_alu_top twa_checker u_twa_checker (.*);

// File: test/tagged_word_alu_top_tb.sv
`timescale 1ns / 1ps

module tagged_word_alu_top_tb;
    import twa_pkg::*;

    localparam int PipeDepth = DivSteps + 2;

    // kinds past the last assigned one answer the false word
    localparam logic [3:0] KIND_SPARE_LO = 4'd14;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] opa;
        logic [63:0] opb;
        logic [63:0] word;
        logic [1:0]  code;
    } t_alu_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_kind;
    logic [63:0] i_operand_a;
    logic [63:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_word;
    logic [1:0]  o_error_code;

    t_alu_expect expected_results[$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    int          rx_hold_cycles = 0;

    tagged_word_alu_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_word (o_result_word),
        .o_error_code  (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] truth_word(input logic cond);
        return cond ? WORD_TRUE : WORD_FALSE;
    endfunction

    function automatic t_alu_expect predict_alu(input logic [3:0] kind,
                                                input logic [63:0] opa,
                                                input logic [63:0] opb);
        t_alu_expect        e;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] q;
        e.kind = kind;
        e.opa  = opa;
        e.opb  = opb;
        e.word = WORD_FALSE;
        e.code = ERR_NONE;
        x = opa[63:32];
        y = opb[63:32];
        q = '0;
        if (kind <= KIND_LESSEQ) begin
            if (opa[2:0] != TAG_INT) begin
                e.code = ERR_A_TAG;
            end else if (opb[2:0] != TAG_INT) begin
                e.code = ERR_B_TAG;
            end else begin
                case (kind)
                    KIND_ADD: q = x + y;
                    KIND_SUB: q = x - y;
                    KIND_MUL: q = x * y;
                    KIND_DIV: begin
                        // minimum over minus one wraps back to minimum
                        if (y == 0)
                            e.code = ERR_DIV0;
                        else if (x == INT_MIN && y == -1)
                            q = x;
                        else
                            q = x / y;
                    end
                    KIND_NUMEQ: e.word = truth_word(x == y);
                    KIND_LESS:  e.word = truth_word(x < y);
                    default:    e.word = truth_word(x <= y);
                endcase
                if (kind <= KIND_DIV)
                    e.word = {q, 29'd0, TAG_INT};
            end
        end else begin
            case (kind)
                KIND_EQ:     e.word = truth_word(opa == opb);
                KIND_ISINT:  e.word = truth_word(opa[2:0] == TAG_INT);
                KIND_ISVOID: e.word = truth_word(opa == WORD_VOID);
                KIND_ISPROC: e.word = truth_word(opa[2:0] == TAG_PROC);
                KIND_ISNULL: e.word = truth_word(opa == WORD_NULL);
                KIND_ISCONS: e.word = truth_word(opa[2:0] == TAG_CONS);
                KIND_NOT:    e.word = truth_word(opa == WORD_FALSE);
                default:     e.word = WORD_FALSE;
            endcase
        end
        if (e.code != ERR_NONE)
            e.word = '0;
        return e;
    endfunction

    // integer word with random filler between the value and the tag
    function automatic logic [63:0] mk_int(input logic signed [31:0] v);
        logic [28:0] filler;
        filler = 29'($urandom());
        return {v, filler, TAG_INT};
    endfunction

    function automatic logic signed [31:0] rand_int_value();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return INT_MIN;
            4: return INT_MAX;
            5: return $urandom_range(16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] rand_operand();
        int r;
        r = $urandom_range(99);
        if (r < 82) begin
            return mk_int(rand_int_value());
        end else if (r < 90) begin
            case ($urandom_range(3))
                0: return WORD_NULL;
                1: return WORD_FALSE;
                2: return WORD_TRUE;
                default: return WORD_VOID;
            endcase
        end else begin
            return {$urandom(), $urandom()};
        end
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_op(input logic [3:0] kind, input logic [63:0] opa,
                           input logic [63:0] opb);
        while (!quiet && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_operand_a <= opa;
        i_operand_b <= opb;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        expected_results.push_back(predict_alu(kind, opa, opb));
    endtask

    task automatic send_random_op();
        logic [3:0]  kind;
        logic [63:0] opa;
        logic [63:0] opb;
        int          r;
        r = $urandom_range(99);
        if (r < 62)
            kind = 4'($urandom_range(KIND_LESSEQ, KIND_ADD));
        else if (r < 97)
            kind = 4'($urandom_range(KIND_NOT, KIND_EQ));
        else
            kind = 4'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        opa = rand_operand();
        opb = rand_operand();
        r = $urandom_range(99);
        if (kind == KIND_EQ && r < 30)
            opb = opa;
        else if (kind == KIND_DIV && r < 12)
            opb = mk_int(0);
        else if (kind >= KIND_NUMEQ && kind <= KIND_LESSEQ && r < 25)
            opb = mk_int(opa[63:32]);
        send_op(kind, opa, opb);
    endtask

    task automatic test_directed();
        send_op(KIND_ADD, mk_int(INT_MAX), mk_int(1));
        send_op(KIND_ADD, mk_int(INT_MIN), mk_int(-1));
        send_op(KIND_SUB, mk_int(INT_MIN), mk_int(1));
        send_op(KIND_MUL, mk_int(32'sd65536), mk_int(32'sd65536));
        send_op(KIND_MUL, mk_int(INT_MAX), mk_int(INT_MAX));
        send_op(KIND_DIV, mk_int(32'sd7), mk_int(-2));
        send_op(KIND_DIV, mk_int(-7), mk_int(32'sd2));
        send_op(KIND_DIV, mk_int(INT_MIN), mk_int(-1));
        send_op(KIND_DIV, mk_int(32'sd5), {32'd0, 29'h1fff_ffff, TAG_INT});
        send_op(KIND_DIV, mk_int(0), mk_int(0));
        send_op(KIND_NUMEQ, mk_int(-1), mk_int(-1));
        send_op(KIND_LESS, mk_int(INT_MIN), mk_int(INT_MAX));
        send_op(KIND_LESSEQ, mk_int(INT_MAX), mk_int(INT_MIN));
        send_op(KIND_ADD, 64'hffff_ffff_ffff_ffff, mk_int(1));
        send_op(KIND_SUB, mk_int(1), 64'hffff_ffff_ffff_fffb);
        send_op(KIND_LESSEQ, WORD_TRUE, WORD_FALSE);
        send_op(KIND_EQ, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_op(KIND_EQ, 64'h8000_0000_0000_0000, 64'h0);
        send_op(KIND_ISINT, mk_int(INT_MIN), 64'h0);
        send_op(KIND_ISVOID, WORD_VOID, 64'hffff_ffff_ffff_ffff);
        send_op(KIND_ISPROC, 64'hffff_ffff_ffff_fff8, 64'h0);
        send_op(KIND_ISNULL, 64'h8000_0000_0000_0000, 64'h0);
        send_op(KIND_ISCONS, 64'h1, 64'h0);
        send_op(KIND_NOT, WORD_FALSE, 64'h0);
        send_op(KIND_NOT, WORD_TRUE, 64'h0);
        send_op(KIND_SPARE_LO, mk_int(1), mk_int(1));
        send_op(KIND_SPARE_HI, WORD_TRUE, WORD_TRUE);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_random_op();
    endtask

    task automatic test_quiet_stream(input int count);
        quiet = 1'b1;
        repeat (count)
            send_random_op();
        quiet = 1'b0;
    endtask

    // hold the receiver off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        rx_hold_cycles = 4 * PipeDepth;
        repeat (100)
            send_random_op();
    endtask

    task automatic test_sender_pause();
        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : rx_ready_gen
        int held;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_ready <= 1'b0;
                for (held = 0; held < rx_hold_cycles; held++)
                    @(posedge i_clk);
                rx_hold_cycles = 0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_alu_expect exp_item;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result word=%h code=%0d",
                                       o_result_word, o_error_code));
            end else begin
                exp_item = expected_results.pop_front();
                if (o_result_word !== exp_item.word)
                    note_failure($sformatf(
                        "kind %0d a=%h b=%h: word exp %h got %h", exp_item.kind,
                        exp_item.opa, exp_item.opb, exp_item.word, o_result_word));
                if (o_error_code !== exp_item.code)
                    note_failure($sformatf(
                        "kind %0d a=%h b=%h: code exp %0d got %0d", exp_item.kind,
                        exp_item.opa, exp_item.opb, exp_item.code, o_error_code));
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_kind      <= KIND_ADD;
        i_operand_a <= '0;
        i_operand_b <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(700);
        test_backpressure();
        test_sender_pause();
        test_quiet_stream(300);
        test_random_mix(500);

        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (PipeDepth + 8) @(posedge i_clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
